@@ src/dtr_pkg.sv @@
// ============================================================================
// dtr_pkg: shared types and constants for duplicate track removal
// Holds the transfer structs of both channels, the stored track record and
// the configuration register map.
// ============================================================================
package dtr_pkg;

  // Configuration port geometry and register map.
  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_MATCH_WINDOW = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_KEEP_FLAG    = 1'b1;

  localparam logic [14:0] MATCH_WINDOW_RESET = 15'd41;
  localparam logic [15:0] KEEP_FLAG_RESET    = 16'd222;

  // One input track.
  typedef struct packed {
    logic signed [15:0] slope_x;
    logic signed [15:0] slope_y;
    logic [15:0]        slope_sq;
    logic [23:0]        event_id;
    logic signed [15:0] parent_id;
    logic [15:0]        track_flag;
    logic               last_track;
  } item_t;

  // One result.
  typedef struct packed {
    logic signed [15:0] out_slope_x;
    logic signed [15:0] out_slope_y;
    logic [15:0]        out_slope_sq;
    logic [23:0]        out_event_id;
    logic signed [15:0] out_parent_id;
    logic               none_kept;
    logic               last_result;
  } result_t;

  // Track record as held in the track store.
  typedef struct packed {
    logic signed [15:0] slope_x;
    logic signed [15:0] slope_y;
    logic [15:0]        slope_sq;
    logic [23:0]        event_id;
    logic signed [15:0] parent_id;
    logic [15:0]        track_flag;
  } track_t;

endpackage

@@ src/dtr_ram.sv @@
// ============================================================================
// dtr_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered.
// ============================================================================
module dtr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/duplicate_track_removal_top.sv @@
// ============================================================================
// duplicate_track_removal_top: clone track removal by slope window
// Loads a batch of tracks, then removes clones within each event and reports
// the surviving tracks whose flag matches keep_flag.
// ============================================================================
// Loading takes one track transfer per cycle; busy stays low until the closing track.
// After it the scan holds busy high until it returns to idle; every store and mark
//   read is registered, so each visited track passes through a wait state and a use
//   state. Results are one-cycle strobes the receiver cannot stall.
// Synchronous active-high reset empties the batch and restores the register
//   defaults; the contents of the track store are left as they are.
module duplicate_track_removal_top #(
  parameter int unsigned MAX_TRACKS = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  // Command channel for tracks.
  input  logic                              start,
  output logic                              busy,
  input  dtr_pkg::item_t                    item,
  // Result channel.
  output logic                              result_valid,
  output dtr_pkg::result_t                  result,
  // Configuration write port.
  input  logic                              cfg_we,
  input  logic [dtr_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [dtr_pkg::CFG_DATA_W-1:0]    cfg_data
);

  // Index width addresses the store; count width can also hold MAX_TRACKS.
  localparam int unsigned IW = $clog2(MAX_TRACKS);
  localparam int unsigned CW = $clog2(MAX_TRACKS + 1);
  localparam int unsigned RW = $bits(dtr_pkg::track_t);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_I_NEXT,
    ST_I_USE,
    ST_R_WAIT,
    ST_R_USE,
    ST_K_WAIT,
    ST_K_USE,
    ST_EMIT,
    ST_FINISH
  } state_t;

  state_t state;

  // Configuration registers.
  logic [14:0] match_window;
  logic [15:0] keep_flag;

  // Batch bookkeeping.
  logic [CW-1:0]         count;
  logic [CW-1:0]         i;
  logic [CW-1:0]         r;
  logic [CW-1:0]         k;
  logic [23:0]           ev_ref;
  dtr_pkg::track_t       ref_rec;
  dtr_pkg::track_t       pend;
  logic                  have_pend;

  // Track store: two copies written together, one read by the reference
  // loop and one by the compare loop.
  logic            store_we;
  dtr_pkg::track_t store_wdata;
  logic [RW-1:0]   rdata_a;
  logic [RW-1:0]   rdata_b;
  dtr_pkg::track_t rec_a;
  dtr_pkg::track_t rec_b;

  // Discard and event-done marks live in small memories. Each entry is
  // zeroed when its track is loaded, so only marks of the current batch are
  // ever read.
  logic          disc_we;
  logic [IW-1:0] disc_waddr;
  logic          disc_wdata;
  logic          disc_r;
  logic          disc_k;
  logic          evd_we;
  logic [IW-1:0] evd_waddr;
  logic          evd_wdata;
  logic          evd_i;
  logic          hit;

  // Shared window compare unit.
  logic signed [16:0] dx;
  logic signed [16:0] dy;
  logic signed [16:0] win;
  logic               in_win;
  logic               same_a;
  logic               r_last;
  logic               k_last;

  function automatic dtr_pkg::result_t make_result(dtr_pkg::track_t t, logic last);
    dtr_pkg::result_t res;
    res.out_slope_x   = t.slope_x;
    res.out_slope_y   = t.slope_y;
    res.out_slope_sq  = t.slope_sq;
    res.out_event_id  = t.event_id;
    res.out_parent_id = t.parent_id;
    res.none_kept     = 1'b0;
    res.last_result   = last;
    return res;
  endfunction

  // The single closing result of a batch that kept nothing.
  function automatic dtr_pkg::result_t make_none();
    dtr_pkg::result_t res;
    res             = '0;
    res.none_kept   = 1'b1;
    res.last_result = 1'b1;
    return res;
  endfunction

  assign busy = (state != ST_IDLE);

  // A track is stored only while there is room; a dropped track may still
  // close the batch.
  assign store_we = (state == ST_IDLE) && start && (count < CW'(MAX_TRACKS));

  always_comb begin
    store_wdata.slope_x    = item.slope_x;
    store_wdata.slope_y    = item.slope_y;
    store_wdata.slope_sq   = item.slope_sq;
    store_wdata.event_id   = item.event_id;
    store_wdata.parent_id  = item.parent_id;
    store_wdata.track_flag = item.track_flag;
  end

  dtr_ram #(
    .WIDTH (RW),
    .DEPTH (MAX_TRACKS)
  ) u_store_a (
    .clk   (clk),
    .we    (store_we),
    .waddr (count[IW-1:0]),
    .wdata (store_wdata),
    .raddr (r[IW-1:0]),
    .rdata (rdata_a)
  );

  dtr_ram #(
    .WIDTH (RW),
    .DEPTH (MAX_TRACKS)
  ) u_store_b (
    .clk   (clk),
    .we    (store_we),
    .waddr (count[IW-1:0]),
    .wdata (store_wdata),
    .raddr (k[IW-1:0]),
    .rdata (rdata_b)
  );

  assign rec_a = dtr_pkg::track_t'(rdata_a);
  assign rec_b = dtr_pkg::track_t'(rdata_b);

  // A live track of the event inside the window of the reference is a clone.
  assign hit = (state == ST_K_USE) && (k != r) && (rec_b.event_id == ev_ref) &&
               !disc_k && in_win;

  // Loading clears the marks of the new entry; the scan only ever sets them.
  assign disc_we    = store_we || hit;
  assign disc_waddr = store_we ? count[IW-1:0] : k[IW-1:0];
  assign disc_wdata = !store_we;
  assign evd_we     = store_we || ((state == ST_R_USE) && same_a);
  assign evd_waddr  = store_we ? count[IW-1:0] : r[IW-1:0];
  assign evd_wdata  = !store_we;

  dtr_ram #(
    .WIDTH (1),
    .DEPTH (MAX_TRACKS)
  ) u_disc_a (
    .clk   (clk),
    .we    (disc_we),
    .waddr (disc_waddr),
    .wdata (disc_wdata),
    .raddr (r[IW-1:0]),
    .rdata (disc_r)
  );

  dtr_ram #(
    .WIDTH (1),
    .DEPTH (MAX_TRACKS)
  ) u_disc_b (
    .clk   (clk),
    .we    (disc_we),
    .waddr (disc_waddr),
    .wdata (disc_wdata),
    .raddr (k[IW-1:0]),
    .rdata (disc_k)
  );

  dtr_ram #(
    .WIDTH (1),
    .DEPTH (MAX_TRACKS)
  ) u_evdone (
    .clk   (clk),
    .we    (evd_we),
    .waddr (evd_waddr),
    .wdata (evd_wdata),
    .raddr (i[IW-1:0]),
    .rdata (evd_i)
  );

  // Both differences must lie strictly inside (-window, +window). Seventeen
  // bits hold every difference of two Q3.12 slopes without overflow.
  always_comb begin
    dx     = {ref_rec.slope_x[15], ref_rec.slope_x} - {rec_b.slope_x[15], rec_b.slope_x};
    dy     = {ref_rec.slope_y[15], ref_rec.slope_y} - {rec_b.slope_y[15], rec_b.slope_y};
    win    = signed'({2'b00, match_window});
    in_win = (dx < win) && (dx > -win) && (dy < win) && (dy > -win);
  end

  // The first track of an event sets the event id for the whole walk.
  assign same_a = (r == i) || (rec_a.event_id == ev_ref);
  assign r_last = ((r + CW'(1)) == count);
  assign k_last = ((k + CW'(1)) == count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      match_window <= dtr_pkg::MATCH_WINDOW_RESET;
      keep_flag    <= dtr_pkg::KEEP_FLAG_RESET;
      count        <= '0;
      have_pend    <= 1'b0;
      result_valid <= 1'b0;
      i            <= '0;
      r            <= '0;
      k            <= '0;
    end else begin
      result_valid <= 1'b0;

      if (cfg_we) begin
        case (cfg_index)
          dtr_pkg::REG_MATCH_WINDOW: match_window <= cfg_data[14:0];
          dtr_pkg::REG_KEEP_FLAG:    keep_flag    <= cfg_data;
          default: ;
        endcase
      end

      case (state)
        ST_IDLE: begin
          if (start) begin
            if (count < CW'(MAX_TRACKS)) begin
              count <= count + CW'(1);
            end
            if (item.last_track) begin
              i     <= '0;
              state <= ST_I_NEXT;
            end
          end
        end

        // Step to the next track; its event-done mark is read meanwhile.
        ST_I_NEXT: begin
          if (i == count) begin
            state <= ST_FINISH;
          end else begin
            state <= ST_I_USE;
          end
        end

        // Skip tracks whose event has already been walked.
        ST_I_USE: begin
          if (evd_i) begin
            i     <= i + CW'(1);
            state <= ST_I_NEXT;
          end else begin
            r     <= i;
            state <= ST_R_WAIT;
          end
        end

        ST_R_WAIT: begin
          state <= ST_R_USE;
        end

        // A surviving track of the current event becomes the reference.
        ST_R_USE: begin
          if (r == i) begin
            ev_ref <= rec_a.event_id;
          end
          if (same_a && !disc_r) begin
            ref_rec <= rec_a;
            k       <= i;
            state   <= ST_K_WAIT;
          end else if (r_last) begin
            i     <= i + CW'(1);
            state <= ST_I_NEXT;
          end else begin
            r     <= r + CW'(1);
            state <= ST_R_WAIT;
          end
        end

        ST_K_WAIT: begin
          state <= ST_K_USE;
        end

        // Clones found here are marked through the discard memory port.
        ST_K_USE: begin
          if (k_last) begin
            state <= ST_EMIT;
          end else begin
            k     <= k + CW'(1);
            state <= ST_K_WAIT;
          end
        end

        // Kept tracks pass through a one-deep holding register so that the
        // final one can carry last_result.
        ST_EMIT: begin
          if (ref_rec.track_flag == keep_flag) begin
            if (have_pend) begin
              result_valid <= 1'b1;
              result       <= make_result(pend, 1'b0);
            end
            pend      <= ref_rec;
            have_pend <= 1'b1;
          end
          if (r_last) begin
            i     <= i + CW'(1);
            state <= ST_I_NEXT;
          end else begin
            r     <= r + CW'(1);
            state <= ST_R_WAIT;
          end
        end

        ST_FINISH: begin
          result_valid <= 1'b1;
          if (have_pend) begin
            result <= make_result(pend, 1'b1);
          end else begin
            result <= make_none();
          end
          count     <= '0;
          have_pend <= 1'b0;
          state     <= ST_IDLE;
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // An empty batch result is always the closing transfer.
  a_none_is_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.none_kept |-> result.last_result)
    else $error("none_kept result without last_result");

  // The closing transfer leaves the block idle with an empty batch.
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.last_result |-> (state == ST_IDLE) && (count == '0))
    else $error("batch not cleared at closing transfer");

  // A scan never runs over an empty store.
  a_scan_has_tracks: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> (count != '0))
    else $error("scan with no stored tracks");

  // The reference track is never discarded during its own compare sweep.
  a_ref_alive: assert property (@(posedge clk) disable iff (rst)
    (state == ST_K_USE) && (k == r) |-> !disc_we)
    else $error("reference track discarded itself");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_TRACKS))
    else $error("track count beyond store depth");

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 100ps
// ============================================================================
// testbench: self-checking bench for duplicate_track_removal_top
// Sends batches of tracks through the start/busy command port, predicts the
// surviving tracks of every batch with a shadow copy of the store and the
// registers, and checks each result strobe against the oldest prediction.
// ============================================================================
module testbench;

  localparam int TRACK_CAP     = 64;
  localparam int RESET_CYCLES  = 11;
  // The limit exceeds the longest scan of a full store, which can pass with no
  // result in between.
  localparam int STALL_LIMIT   = 65000;
  // Cycles allowed after the last result for the block to settle.
  localparam int SETTLE_CYCLES = 16;
  localparam int PHASE_TRACKS  = 86;

  logic                            clk;
  logic                            rst;
  logic                            start;
  logic                            busy;
  dtr_pkg::item_t                  item;
  logic                            result_valid;
  dtr_pkg::result_t                result;
  logic                            cfg_we;
  logic [dtr_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [dtr_pkg::CFG_DATA_W-1:0]  cfg_data;

  duplicate_track_removal_top #(
    .MAX_TRACKS(TRACK_CAP)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .item(item),
    .result_valid(result_valid),
    .result(result),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Shadow copy of the block: track store, fill level and both registers.
  dtr_pkg::track_t shadow_store [TRACK_CAP];
  int              shadow_count;
  logic [14:0]     shadow_window;
  logic [15:0]     shadow_keep;

  // Surviving tracks still to come out of the block, oldest first.
  dtr_pkg::result_t kept_track_q [$];

  int unsigned sender_idle_pct = 0;
  int unsigned quiet_cycles = 0;
  int unsigned error_count = 0;
  int unsigned tracks_sent = 0;
  int unsigned batches_closed = 0;
  int unsigned empty_batches = 0;
  int unsigned dropped_tracks = 0;
  int unsigned results_checked = 0;
  int unsigned settings_written = 0;

  always #2 clk = ~clk;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Walks the events in order of first appearance. Inside an event, every
  // track that is still alive discards the other live tracks whose x and y
  // slope differences both lie strictly inside the window, and is then kept
  // if its flag equals the keep flag.
  function automatic void predict_survivors();
    bit               event_seen [TRACK_CAP];
    bit               discarded [TRACK_CAP];
    dtr_pkg::result_t batch_q [$];
    dtr_pkg::result_t kept;
    logic [23:0]      ev;
    int               w;
    int               dx;
    int               dy;
    w = int'(shadow_window);
    for (int i = 0; i < shadow_count; i++) begin
      if (event_seen[i]) continue;
      ev = shadow_store[i].event_id;
      for (int k = i; k < shadow_count; k++) begin
        if (shadow_store[k].event_id == ev) event_seen[k] = 1'b1;
      end
      for (int ri = i; ri < shadow_count; ri++) begin
        if (shadow_store[ri].event_id != ev || discarded[ri]) continue;
        for (int ki = i; ki < shadow_count; ki++) begin
          if (ki == ri || shadow_store[ki].event_id != ev || discarded[ki]) continue;
          dx = int'(shadow_store[ri].slope_x) - int'(shadow_store[ki].slope_x);
          dy = int'(shadow_store[ri].slope_y) - int'(shadow_store[ki].slope_y);
          if (dx < w && dx > -w && dy < w && dy > -w) discarded[ki] = 1'b1;
        end
        if (shadow_store[ri].track_flag == shadow_keep) begin
          kept = '0;
          kept.out_slope_x   = shadow_store[ri].slope_x;
          kept.out_slope_y   = shadow_store[ri].slope_y;
          kept.out_slope_sq  = shadow_store[ri].slope_sq;
          kept.out_event_id  = shadow_store[ri].event_id;
          kept.out_parent_id = shadow_store[ri].parent_id;
          batch_q = {batch_q, kept};
        end
      end
    end
    // A batch that keeps nothing still reports once, with only the flags set.
    if (batch_q.size() == 0) begin
      kept = '0;
      kept.none_kept = 1'b1;
      batch_q = {batch_q, kept};
      empty_batches++;
    end
    foreach (batch_q[j]) begin
      kept = batch_q[j];
      kept.last_result = (j == batch_q.size() - 1);
      kept_track_q = {kept_track_q, kept};
    end
  endfunction

  // Called at the edge where the block takes a track.
  function automatic void take_track(input dtr_pkg::item_t t);
    tracks_sent++;
    if (shadow_count < TRACK_CAP) begin
      shadow_store[shadow_count] = '{t.slope_x, t.slope_y, t.slope_sq, t.event_id,
                                     t.parent_id, t.track_flag};
      shadow_count++;
    end else begin
      dropped_tracks++;
    end
    if (t.last_track) begin
      predict_survivors();
      batches_closed++;
      shadow_count = 0;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------

  function automatic void check_field(input string name, input logic [23:0] want,
                                      input logic [23:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin
    dtr_pkg::result_t want;
    if (!rst && result_valid) begin
      if (kept_track_q.size() == 0) begin
        $display("%0t: result with nothing expected: expected none, got %h",
                 $time, result);
        error_count++;
      end else begin
        want = kept_track_q.pop_front();
        results_checked++;
        check_field("out_slope_x", 24'(want.out_slope_x), 24'(result.out_slope_x));
        check_field("out_slope_y", 24'(want.out_slope_y), 24'(result.out_slope_y));
        check_field("out_slope_sq", 24'(want.out_slope_sq), 24'(result.out_slope_sq));
        check_field("out_event_id", want.out_event_id, result.out_event_id);
        check_field("out_parent_id", 24'(want.out_parent_id),
                    24'(result.out_parent_id));
        check_field("none_kept", 24'(want.none_kept), 24'(result.none_kept));
        check_field("last_result", 24'(want.last_result), 24'(result.last_result));
      end
    end
  end

  // Ends the run when neither channel has moved a transfer for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                 $time, STALL_LIMIT, kept_track_q.size());
        $display("FAIL");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Offers one track and holds it until the block takes it. Inside a batch start
  // drops only for random idle gaps, so tracks can go back to back; after the
  // closing track it drops so the block does not take the same track again.
  task automatic send_track(input dtr_pkg::item_t t);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    item  <= t;
    do @(posedge clk); while (busy);
    take_track(t);
    if (t.last_track) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Waits until every predicted result has come and the block is idle.
  task automatic wait_until_drained();
    while (kept_track_q.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes both registers while the block is idle. Bit 15 of the window
  // write lands outside the 15-bit register and must be ignored.
  task automatic write_settings(input logic [15:0] window_data,
                                input logic [15:0] keep_data);
    wait_until_drained();
    cfg_we    <= 1'b1;
    cfg_index <= dtr_pkg::REG_MATCH_WINDOW;
    cfg_data  <= window_data;
    @(posedge clk);
    shadow_window = window_data[14:0];
    cfg_index <= dtr_pkg::REG_KEEP_FLAG;
    cfg_data  <= keep_data;
    @(posedge clk);
    shadow_keep = keep_data;
    cfg_we <= 1'b0;
    @(posedge clk);
    settings_written++;
  endtask

  function automatic dtr_pkg::item_t track(input int sx, input int sy,
                                           input logic [15:0] sq,
                                           input logic [23:0] ev, input int parent,
                                           input logic [15:0] flag, input bit last);
    dtr_pkg::item_t t;
    t.slope_x    = sx[15:0];
    t.slope_y    = sy[15:0];
    t.slope_sq   = sq;
    t.event_id   = ev;
    t.parent_id  = parent[15:0];
    t.track_flag = flag;
    t.last_track = last;
    return t;
  endfunction

  function automatic int clamp_slope(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Window writes lean on the extremes and on small values where clones are
  // common; the top bit of the write data is random.
  function automatic logic [15:0] pick_window();
    logic [15:0] w;
    case ($urandom_range(5))
      0: w = 16'd0;
      1: w = 16'h7FFF;
      2: w = 16'($urandom_range(1, 64));
      3: w = 16'($urandom_range(65, 2048));
      default: w = 16'($urandom);
    endcase
    w[15] = 1'($urandom_range(1));
    return w;
  endfunction

  function automatic logic [15:0] pick_keep();
    case ($urandom_range(4))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return dtr_pkg::KEEP_FLAG_RESET;
      default: return 16'($urandom);
    endcase
  endfunction

  // One batch of n tracks spread over up to four events. Slopes cluster
  // around a random center per event so that clones within the window are
  // common, with some tracks placed exactly on the window edge.
  task automatic send_random_batch(input int n);
    logic [23:0] ev_ids [4];
    int          center_x [4];
    int          center_y [4];
    int          n_events;
    int          e;
    int          span;
    int          sx;
    int          sy;
    int          w;
    logic [15:0] flag;
    n_events = $urandom_range(1, 4);
    w = int'(shadow_window);
    span = (w < 2) ? 4 : 2 * w;
    if (span > 16384) span = 16384;
    for (int j = 0; j < n_events; j++) begin
      ev_ids[j]   = 24'($urandom);
      center_x[j] = int'($signed(16'($urandom)));
      center_y[j] = int'($signed(16'($urandom)));
    end
    for (int j = 0; j < n; j++) begin
      e = $urandom_range(n_events - 1);
      case ($urandom_range(7))
        0: begin
          sx = center_x[e];
          sy = center_y[e];
        end
        1: begin
          sx = center_x[e] + (($urandom_range(1) == 1) ? w : -w);
          sy = center_y[e] + int'($urandom_range(2 * w)) - w;
        end
        2: begin
          sx = int'($signed(16'($urandom)));
          sy = int'($signed(16'($urandom)));
        end
        default: begin
          sx = center_x[e] + int'($urandom_range(2 * span)) - span;
          sy = center_y[e] + int'($urandom_range(2 * span)) - span;
        end
      endcase
      flag = ($urandom_range(9) < 6) ? shadow_keep : 16'($urandom);
      send_track(track(clamp_slope(sx), clamp_slope(sy), 16'($urandom), ev_ids[e],
                       int'($urandom), flag, j == n - 1));
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset values of the registers: one kept track with every output field at an
  // extreme, then a batch whose only track misses the keep flag.
  task automatic test_reset_defaults();
    send_track(track(-32768, 32767, 16'hFFFF, 24'hFFFFFF, -32768,
                     dtr_pkg::KEEP_FLAG_RESET, 1'b1));
    send_track(track(32767, -32768, 16'h0000, 24'h000000, 32767,
                     dtr_pkg::KEEP_FLAG_RESET + 16'd1, 1'b1));
  endtask

  // Clones just inside the window, tracks exactly on its edge, a clone taken
  // out by a later reference, a second event interleaved with the first, and
  // a survivor whose flag does not match.
  task automatic test_clone_window();
    write_settings(16'd100, 16'h5A5A);
    send_track(track(0, 0, 16'h1000, 24'h00A5A5, 1, 16'h5A5A, 1'b0));
    send_track(track(99, -99, 16'h1001, 24'h00A5A5, 2, 16'h5A5A, 1'b0));
    send_track(track(100, 0, 16'h1002, 24'h00A5A5, 3, 16'h5A5A, 1'b0));
    send_track(track(0, 0, 16'h1003, 24'h5A5A5A, 4, 16'h5A5A, 1'b0));
    send_track(track(-99, 99, 16'h1004, 24'h00A5A5, 5, 16'h5A5A, 1'b0));
    send_track(track(5000, 5000, 16'h1005, 24'h00A5A5, 6, 16'hA5A5, 1'b0));
    send_track(track(32767, -32768, 16'h1006, 24'h5A5A5A, -7, 16'h5A5A, 1'b0));
    send_track(track(150, 20, 16'h1007, 24'h00A5A5, 8, 16'h5A5A, 1'b1));
  endtask

  // A zero window lets identical tracks all survive; the widest window still
  // cannot join slopes at opposite ends of the range.
  task automatic test_window_extremes();
    write_settings(16'd0, 16'hFFFF);
    send_track(track(1234, -1234, 16'h0123, 24'h123456, -1, 16'hFFFF, 1'b0));
    send_track(track(1234, -1234, 16'h0456, 24'h123456, -2, 16'hFFFF, 1'b0));
    send_track(track(1234, -1234, 16'h0789, 24'h123456, -3, 16'hFFFF, 1'b1));
    write_settings(16'hFFFF, 16'h0000);
    send_track(track(32767, 0, 16'h8000, 24'h800000, 100, 16'h0000, 1'b0));
    send_track(track(-32768, 0, 16'h4000, 24'h800000, 200, 16'h0000, 1'b0));
    send_track(track(0, 0, 16'h2000, 24'h800000, 300, 16'h0000, 1'b0));
    send_track(track(1, 1, 16'h0001, 24'h800000, 400, 16'h0000, 1'b1));
  endtask

  // One batch that fills the store exactly and one that runs past it; the
  // extra tracks are dropped but the closing one still ends the batch.
  task automatic test_store_full();
    write_settings(16'($urandom_range(1, 300)), pick_keep());
    send_random_batch(TRACK_CAP);
    write_settings(pick_window(), pick_keep());
    send_random_batch(TRACK_CAP + $urandom_range(1, 5));
  endtask

  // Mostly small batches with fresh settings now and then.
  task automatic test_random_traffic(input int unsigned idle_pct, input int n_tracks);
    int sent;
    int n;
    sender_idle_pct = idle_pct;
    sent = 0;
    while (sent < n_tracks) begin
      if ($urandom_range(2) == 0) write_settings(pick_window(), pick_keep());
      n = ($urandom_range(19) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      send_random_batch(n);
      sent += n;
    end
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    shadow_window = dtr_pkg::MATCH_WINDOW_RESET;
    shadow_keep = dtr_pkg::KEEP_FLAG_RESET;
    shadow_count = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_clone_window();
    test_window_extremes();
    test_store_full();
    test_random_traffic(22, PHASE_TRACKS);
    test_random_traffic(56, PHASE_TRACKS);
    test_random_traffic(0, PHASE_TRACKS);

    wait_until_drained();
    $display("Sent %0d tracks in %0d batches (%0d dropped on a full store), %0d settings.",
             tracks_sent, batches_closed, dropped_tracks, settings_written);
    $display("Checked %0d results, %0d of them from batches that kept nothing.",
             results_checked, empty_batches);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/dtr_pkg.sv
src/dtr_ram.sv
src/duplicate_track_removal_top.sv
verif/testbench.sv
